/* hdl/lav_pkg.sv */
// shared types and constants for the look-at view matrix block
`timescale 1ns / 1ps
package lav_pkg;

  localparam int unsigned QW = 32;
  localparam logic signed [QW-1:0] ONE_Q16 = 32'sd65536;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // one accepted item as held in the queue between front and back
  typedef struct packed {
    logic signed [QW-1:0] eye_x;
    logic signed [QW-1:0] eye_y;
    logic signed [QW-1:0] eye_z;
    logic signed [QW:0]   diff_x;
    logic signed [QW:0]   diff_y;
    logic signed [QW:0]   diff_z;
    logic signed [QW-1:0] up_x;
    logic signed [QW-1:0] up_y;
    logic signed [QW-1:0] up_z;
  } lav_item_t;

  // one result row
  typedef struct packed {
    logic [1:0]           row_index;
    logic signed [QW-1:0] c0;
    logic signed [QW-1:0] c1;
    logic signed [QW-1:0] c2;
    logic signed [QW-1:0] c3;
    logic                 degenerate;
    logic                 last_row;
  } lav_row_t;

endpackage

/* hdl/lav_front.sv */
// front end: accepts an item, forms eye minus target, and queues it
`timescale 1ns / 1ps
module lav_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [31:0]   eye_x_i,
  input  logic signed [31:0]   eye_y_i,
  input  logic signed [31:0]   eye_z_i,
  input  logic signed [31:0]   target_x_i,
  input  logic signed [31:0]   target_y_i,
  input  logic signed [31:0]   target_z_i,
  input  logic signed [31:0]   upward_x_i,
  input  logic signed [31:0]   upward_y_i,
  input  logic signed [31:0]   upward_z_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output lav_pkg::lav_item_t   q_item_o
);

  lav_pkg::lav_item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  lav_pkg::lav_item_t item_d;
  logic push, pop;

  // difference vector formed at entry
  always_comb begin
    item_d.eye_x  = eye_x_i;
    item_d.eye_y  = eye_y_i;
    item_d.eye_z  = eye_z_i;
    item_d.diff_x = 33'(eye_x_i) - 33'(target_x_i);
    item_d.diff_y = 33'(eye_y_i) - 33'(target_y_i);
    item_d.diff_z = 33'(eye_z_i) - 33'(target_z_i);
    item_d.up_x   = upward_x_i;
    item_d.up_y   = upward_y_i;
    item_d.up_z   = upward_z_i;
  end

  assign ready_o   = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rp_q];
  assign push      = valid_i && ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item_d;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/lav_isqrt.sv */
// multi-cycle integer square root, one result bit per restoring step
`timescale 1ns / 1ps
module lav_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q, res_q, bit_q;
  logic        busy_q, done_q;
  logic [63:0] n_d, res_d, bit_d, t0, t1;
  logic [63:0] n_1, res_1;

  // two restoring steps per cycle
  always_comb begin
    t0 = res_q + bit_q;
    if (n_q >= t0) begin
      n_1   = n_q - t0;
      res_1 = (res_q >> 1) + bit_q;
    end else begin
      n_1   = n_q;
      res_1 = res_q >> 1;
    end
    t1 = res_1 + (bit_q >> 2);
    if (n_1 >= t1) begin
      n_d   = n_1 - t1;
      res_d = (res_1 >> 1) + (bit_q >> 2);
    end else begin
      n_d   = n_1;
      res_d = res_1 >> 1;
    end
    bit_d = bit_q >> 4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= rad_i;
        res_q  <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end else if (busy_q) begin
        n_q   <= n_d;
        res_q <= res_d;
        bit_q <= bit_d;
        if (bit_d == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

/* hdl/lav_back.sv */
// back end: sequencer that normalizes, crosses and emits the four rows
`timescale 1ns / 1ps
module lav_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  lav_pkg::lav_item_t q_item_i,
  output logic               row_valid_o,
  input  logic               row_ready_i,
  output lav_pkg::lav_row_t  row_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CROSS = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_TMUL  = 4'd9;
  localparam logic [3:0] S_TSUM  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0] st_q;
  logic [1:0] vec_q;     // 0 direction, 1 right, 2 true up
  logic [1:0] k_q;       // component counter
  logic [1:0] row_q;
  logic       bad_q;

  lav_pkg::lav_item_t it_q;
  logic signed [65:0] v_q [3];    // vector being normalized
  logic [64:0]        m_q [3];    // magnitudes, later scaled
  logic [63:0]        sq_q [3];
  logic [31:0]        len_q;
  logic signed [31:0] u_q [3][3]; // unit rows: dir, right, tup
  logic signed [63:0] pp_q [3];
  logic signed [31:0] c3_q;

  // cross-product partial terms over cycles
  logic [1:0]         cx_q;
  logic signed [63:0] ca_q, cb_q;

  // divider
  logic [49:0] num_q;
  logic [49:0] rem_q;
  logic [32:0] den_q;
  logic [17:0] quo_q;
  logic [5:0]  dcnt_q;

  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;
  logic [63:0] rad;

  // sum of squares goes straight into the root unit as it starts
  assign rad = sq_q[0] + sq_q[1] + sq_q[2];

  lav_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // output register
  logic              ov_q;
  lav_pkg::lav_row_t orow_q;
  assign row_valid_o = ov_q;
  assign row_o       = orow_q;
  assign q_ready_o   = (st_q == S_IDLE);
  assign sq_start    = (st_q == S_SUM);

  // helpers
  logic [64:0] top;
  logic [6:0]  msb;
  logic signed [32:0] ua, ub;
  logic signed [31:0] eye_k;
  logic signed [64:0] tsum;
  logic signed [48:0] tq;
  logic [50:0] rtry;

  always_comb begin
    top = m_q[0];
    if (m_q[1] > top) top = m_q[1];
    if (m_q[2] > top) top = m_q[2];
    msb = '0;
    for (int i = 0; i < 65; i++) begin
      if (top[i]) msb = 7'(i);
    end
  end

  always_comb begin
    case (k_q)
      2'd0:    eye_k = it_q.eye_x;
      2'd1:    eye_k = it_q.eye_y;
      default: eye_k = it_q.eye_z;
    endcase
  end

  // translation: round half up, negate, saturate
  always_comb begin
    tsum = 65'(pp_q[0]) + 65'(pp_q[1]) + 65'(pp_q[2]) + 65'sd32768;
    tq   = 49'(tsum >>> 16);
    if (-tq > 49'sd2147483647)       c3_q = 32'sh7fff_ffff;
    else if (-tq < -49'sd2147483648) c3_q = 32'sh8000_0000;
    else                             c3_q = 32'(-tq);
  end

  assign rtry = {rem_q[49:0], num_q[49]} - {18'd0, den_q};

  // cross operand selection: vec 1 is up x dir, vec 2 is dir x right
  always_comb begin
    ua = '0;
    ub = '0;
    unique case ({vec_q[1], cx_q})
      3'b000: begin ua = 33'(it_q.up_y); ub = 33'(u_q[0][2]); end
      3'b001: begin ua = 33'(it_q.up_z); ub = 33'(u_q[0][0]); end
      3'b010: begin ua = 33'(it_q.up_x); ub = 33'(u_q[0][1]); end
      3'b100: begin ua = 33'(u_q[0][1]); ub = 33'(u_q[1][2]); end
      3'b101: begin ua = 33'(u_q[0][2]); ub = 33'(u_q[1][0]); end
      3'b110: begin ua = 33'(u_q[0][0]); ub = 33'(u_q[1][1]); end
      default: begin ua = '0; ub = '0; end
    endcase
  end

  logic signed [32:0] va, vb;
  always_comb begin
    unique case ({vec_q[1], cx_q})
      3'b000: begin va = 33'(it_q.up_z); vb = 33'(u_q[0][1]); end
      3'b001: begin va = 33'(it_q.up_x); vb = 33'(u_q[0][2]); end
      3'b010: begin va = 33'(it_q.up_y); vb = 33'(u_q[0][0]); end
      3'b100: begin va = 33'(u_q[0][2]); vb = 33'(u_q[1][1]); end
      3'b101: begin va = 33'(u_q[0][0]); vb = 33'(u_q[1][2]); end
      3'b110: begin va = 33'(u_q[0][1]); vb = 33'(u_q[1][0]); end
      default: begin va = '0; vb = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          it_q   <= q_item_i;
          v_q[0] <= 66'(q_item_i.diff_x);
          v_q[1] <= 66'(q_item_i.diff_y);
          v_q[2] <= 66'(q_item_i.diff_z);
        end
      end
      S_CROSS: begin
        // one product pair per cycle, then subtract next cycle
        ca_q <= 64'(ua * ub);
        cb_q <= 64'(va * vb);
        if (k_q != 2'd0) v_q[cx_q - 2'd1] <= 66'(ca_q) - 66'(cb_q);
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= v_q[i][65] ? 65'(-v_q[i]) : 65'(v_q[i]);
        end
      end
      S_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= (msb < 7'd29) ? m_q[i] << (7'd29 - msb) : m_q[i] >> (msb - 7'd29);
        end
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) sq_q[i] <= 64'(m_q[i][29:0] * m_q[i][29:0]);
      end
      S_ROOT: begin
        if (sq_done) begin
          len_q  <= sq_root;
          num_q  <= {3'd0, m_q[0][29:0], 17'd0} + 50'(sq_root);
          rem_q  <= '0;
          den_q  <= {sq_root, 1'b0};
          dcnt_q <= '0;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!rtry[50]) rem_q <= rtry[49:0];
        else           rem_q <= {rem_q[48:0], num_q[49]};
        num_q  <= {num_q[48:0], 1'b0};
        quo_q  <= {quo_q[16:0], ~rtry[50]};
        dcnt_q <= dcnt_q + 6'd1;
      end
      S_STORE: begin
        u_q[vec_q][k_q] <= v_q[k_q][65] ? -32'(quo_q) : 32'(quo_q);
        num_q  <= {3'd0, (k_q == 2'd0 ? m_q[1][29:0] : m_q[2][29:0]), 17'd0}
                  + 50'(len_q);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      S_TMUL: begin
        pp_q[k_q] <= 64'(u_q[row_q == 2'd0 ? 2'd1 : (row_q == 2'd1 ? 2'd2 : 2'd0)][k_q]
                     * eye_k);
      end
      default: ;
    endcase
    if (st_q == S_IDLE) quo_q <= '0;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      vec_q  <= '0;
      k_q    <= '0;
      cx_q   <= '0;
      row_q  <= '0;
      bad_q  <= 1'b0;
      ov_q   <= 1'b0;
      orow_q <= '0;
    end else begin
      if (ov_q && row_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            st_q  <= S_PREP;
            vec_q <= 2'd0;
            bad_q <= 1'b0;
          end
        end
        S_CROSS: begin
          k_q  <= 2'd1;
          cx_q <= cx_q + 2'd1;
          if (cx_q == 2'd3) begin
            cx_q <= '0;
            k_q  <= '0;
            st_q <= S_PREP;
          end
        end
        S_PREP:  st_q <= S_SCALE;
        S_SCALE: begin
          if (m_q[0] == '0 && m_q[1] == '0 && m_q[2] == '0) begin
            bad_q <= 1'b1;
            st_q  <= S_TMUL;
            k_q   <= '0;
            row_q <= '0;
          end else begin
            st_q <= S_SQ;
          end
        end
        S_SQ:   st_q <= S_SUM;
        S_SUM:  st_q <= S_ROOT;
        S_ROOT: if (sq_done) st_q <= S_DIV;
        S_DIV:  if (dcnt_q == 6'd49) st_q <= S_STORE;
        S_STORE: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (vec_q == 2'd2) begin
              st_q  <= S_TMUL;
              row_q <= '0;
            end else begin
              vec_q <= vec_q + 2'd1;
              cx_q  <= '0;
              st_q  <= S_CROSS;
            end
          end else begin
            k_q  <= k_q + 2'd1;
            st_q <= S_DIV;
          end
        end
        S_TMUL: begin
          if (k_q == 2'd2) begin
            k_q  <= '0;
            st_q <= S_TSUM;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_TSUM: st_q <= S_EMIT;
        S_EMIT: begin
          if (!ov_q || row_ready_i) begin
            ov_q                <= 1'b1;
            orow_q.row_index    <= row_q;
            orow_q.degenerate   <= bad_q;
            orow_q.last_row     <= (row_q == lav_pkg::ROW_LAST);
            if (row_q == lav_pkg::ROW_LAST || bad_q) begin
              orow_q.c0 <= '0;
              orow_q.c1 <= '0;
              orow_q.c2 <= '0;
              orow_q.c3 <= (row_q == lav_pkg::ROW_LAST) ? lav_pkg::ONE_Q16 : '0;
            end else begin
              orow_q.c0 <= u_q[row_q == 2'd0 ? 2'd1 : (row_q == 2'd1 ? 2'd2 : 2'd0)][0];
              orow_q.c1 <= u_q[row_q == 2'd0 ? 2'd1 : (row_q == 2'd1 ? 2'd2 : 2'd0)][1];
              orow_q.c2 <= u_q[row_q == 2'd0 ? 2'd1 : (row_q == 2'd1 ? 2'd2 : 2'd0)][2];
              orow_q.c3 <= c3_q;
            end
            row_q <= row_q + 2'd1;
            st_q  <= (row_q == lav_pkg::ROW_LAST) ? S_IDLE : S_TMUL;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/look_at_view_matrix_core.sv */
// top level of the look-at view matrix block
`timescale 1ns / 1ps
// Usage:
//  input channel (valid_i / ready_o) takes one item: eye, target and up
//  vector, each component signed Q16.16.
//  output channel (valid_o / ready_i) gives four items per input, rows
//  0 to 3 of the view matrix in order (right, true up, direction, 0001);
//  last_row_o marks row 3, degenerate_o flags a zero-length vector.
//  A front stage forms eye minus target and holds up to two items in a
//  queue, so the next items are taken while the back end works.
//  The back end normalizes three vectors in turn; each takes a square
//  root and three serial divisions. While it works on one item the
//  back end takes no other from the queue: the next is taken only once
//  the last row of the current one has entered the output register.
//  Rows leave through a one-entry output register; when the receiver
//  stalls the sequencer holds on the next row and nothing is lost.
//  Reset clears the queue, the sequencer and the output register; the
//  block is ready as soon as reset is released.
module look_at_view_matrix_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] upward_x_i,
  input  logic signed [31:0] upward_y_i,
  input  logic signed [31:0] upward_z_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col_zero_o,
  output logic signed [31:0] col_one_o,
  output logic signed [31:0] col_two_o,
  output logic signed [31:0] col_three_o,
  output logic               degenerate_o,
  output logic               last_row_o
);

  logic               q_valid, q_ready;
  lav_pkg::lav_item_t q_item;
  lav_pkg::lav_row_t  row;

  lav_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .eye_x_i, .eye_y_i, .eye_z_i,
    .target_x_i, .target_y_i, .target_z_i,
    .upward_x_i, .upward_y_i, .upward_z_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  lav_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .row_valid_o(valid_o), .row_ready_i(ready_i), .row_o(row)
  );

  assign row_index_o  = row.row_index;
  assign col_zero_o   = row.c0;
  assign col_one_o    = row.c1;
  assign col_two_o    = row.c2;
  assign col_three_o  = row.c3;
  assign degenerate_o = row.degenerate;
  assign last_row_o   = row.last_row;

endmodule

/* test/testbench.sv */
// self-checking testbench for the look-at view matrix block
`timescale 1ns / 1ps
module testbench;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               ready_o;
  logic signed [31:0] eye_x_i, eye_y_i, eye_z_i;
  logic signed [31:0] target_x_i, target_y_i, target_z_i;
  logic signed [31:0] upward_x_i, upward_y_i, upward_z_i;
  logic               valid_o;
  logic               ready_i;
  logic [1:0]         row_index_o;
  logic signed [31:0] col_zero_o, col_one_o, col_two_o, col_three_o;
  logic               degenerate_o;
  logic               last_row_o;

  look_at_view_matrix_core uut (.*);

  // rows still owed by the block, oldest first
  lav_pkg::lav_row_t pending_rows[$];
  int       error_count = 0;
  bit       gaps_on = 1'b1;
  bit       stalls_on = 1'b1;
  int       stall_left = 0;

  // clock
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // integer square root, floor
  function automatic bit [63:0] int_sqrt(input bit [63:0] n);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale to unit length in Q16.16; returns 0 on a zero vector
  function automatic bit to_unit(input longint v[3], output longint o[3]);
    bit [63:0] m[3];
    bit [63:0] top, sum, len, q;
    int dn, upn;
    top = 0; sum = 0; dn = 0; upn = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b0;
    end
    while (top >= (64'd1 << 30)) begin top = top >> 1; dn++; end
    while (top < (64'd1 << 29)) begin top = top << 1; upn++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> dn) << upn;
      sum = sum + m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd131072 + len) / (64'd2 * len);
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // minus row dot eye, rounded half up, saturated
  function automatic logic signed [31:0] row_offset(input longint r[3],
                                                     input longint e[3]);
    longint s;
    s = r[0] * e[0] + r[1] * e[1] + r[2] * e[2] + 32768;
    s = -(s >>> 16);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // work out the four view matrix rows of one item
  task automatic predict_rows(input logic signed [31:0] ex, ey, ez,
                              tx, ty, tz, ux, uy, uz);
    longint eye[3], up[3], diff[3], fwd[3], side[3], tup[3], tmp[3];
    longint rows[3][3];
    bit ok;
    lav_pkg::lav_row_t r;
    eye = '{ex, ey, ez};
    up = '{ux, uy, uz};
    diff = '{longint'(ex) - tx, longint'(ey) - ty, longint'(ez) - tz};
    ok = to_unit(diff, fwd);
    cross_prod(up, fwd, tmp);
    ok = to_unit(tmp, side) && ok;
    cross_prod(fwd, side, tmp);
    ok = to_unit(tmp, tup) && ok;
    if (!ok) begin
      fwd = '{0, 0, 0}; side = '{0, 0, 0}; tup = '{0, 0, 0};
    end
    rows[0] = side; rows[1] = tup; rows[2] = fwd;
    for (int k = 0; k < 3; k++) begin
      r.row_index = 2'(k);
      r.c0 = rows[k][0][31:0];
      r.c1 = rows[k][1][31:0];
      r.c2 = rows[k][2][31:0];
      r.c3 = row_offset(rows[k], eye);
      r.degenerate = !ok;
      r.last_row = 1'b0;
      pending_rows.push_back(r);
    end
    r = '{row_index: lav_pkg::ROW_LAST, c0: 0, c1: 0, c2: 0, c3: lav_pkg::ONE_Q16,
          degenerate: !ok, last_row: 1'b1};
    pending_rows.push_back(r);
  endtask

  // drive one item and wait for it to be taken
  task automatic send_item(input logic signed [31:0] ex, ey, ez,
                           tx, ty, tz, ux, uy, uz);
    int n;
    @(negedge clk_i);
    eye_x_i = ex; eye_y_i = ey; eye_z_i = ez;
    target_x_i = tx; target_y_i = ty; target_z_i = tz;
    upward_x_i = ux; upward_y_i = uy; upward_z_i = uz;
    valid_i = 1'b1;
    do @(posedge clk_i); while (!ready_o);
    predict_rows(ex, ey, ez, tx, ty, tz, ux, uy, uz);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      @(negedge clk_i);
      valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        ready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        ready_i <= 1'b1;
        if (stalls_on && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 8);
      end
    end
  end

  // compare each row with the oldest prediction
  always @(posedge clk_i) begin
    lav_pkg::lav_row_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (pending_rows.size() == 0) begin
        $error("row with no item pending: row_index %0d", row_index_o);
        error_count++;
      end else begin
        want = pending_rows.pop_front();
        if (row_index_o !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, row_index_o);
          error_count++;
        end
        if (col_zero_o !== want.c0) begin
          $error("col_zero: expected %0d, got %0d", want.c0, col_zero_o);
          error_count++;
        end
        if (col_one_o !== want.c1) begin
          $error("col_one: expected %0d, got %0d", want.c1, col_one_o);
          error_count++;
        end
        if (col_two_o !== want.c2) begin
          $error("col_two: expected %0d, got %0d", want.c2, col_two_o);
          error_count++;
        end
        if (col_three_o !== want.c3) begin
          $error("col_three: expected %0d, got %0d", want.c3, col_three_o);
          error_count++;
        end
        if (degenerate_o !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, degenerate_o);
          error_count++;
        end
        if (last_row_o !== want.last_row) begin
          $error("last_row: expected %0d, got %0d", want.last_row, last_row_o);
          error_count++;
        end
      end
    end
  end

  // random Q16.16 value of random magnitude
  function automatic logic signed [31:0] rand_q();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  // axis cases, extremes and every degenerate case
  task automatic test_directed();
    localparam logic signed [31:0] MX = 32'sh7fffffff;
    localparam logic signed [31:0] MN = 32'sh80000000;
    send_item(0, 0, 65536, 0, 0, 0, 0, 65536, 0);
    send_item(0, 0, 0, 0, 0, 65536, 0, 65536, 0);
    send_item(65536, 131072, 196608, 0, 0, 0, 0, 0, 65536);
    send_item(MX, MX, MX, MN, MN, MN, 0, MX, 0);
    send_item(MN, MN, MN, MX, MX, MX, MN, 0, MX);
    send_item(MX, MN, MX, MN, MX, MN, MX, MX, MN);
    send_item(MX, MX, MX, 0, 0, 0, MN, MX, MN);
    send_item(MN, MN, MN, 0, 0, 0, 1, -1, 0);
    send_item(1, 0, 0, 0, 0, 0, 0, 1, 0);
    send_item(-1, -1, -1, 0, 0, 0, 1, 0, 0);
    // eye equals target
    send_item(12345, -6789, 42, 12345, -6789, 42, 0, 65536, 0);
    send_item(MX, MN, 0, MX, MN, 0, 0, 65536, 0);
    // zero up vector
    send_item(0, 0, 65536, 0, 0, 0, 0, 0, 0);
    // up parallel to the direction
    send_item(0, 0, 65536, 0, 0, 0, 0, 0, 65536);
    send_item(3, 5, 7, 1, 2, 3, -4, -6, -8);
    send_item(MX, 0, 0, 0, 0, 0, MN, 0, 0);
    send_item(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_item(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
              32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc,
              32'sh55555555, 32'shaaaaaaaa, 32'sh00ff00ff);
  endtask

  // sender holds off until the block has drained
  task automatic test_drain_pause();
    send_item(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
              rand_q(), rand_q(), rand_q());
    @(negedge clk_i);
    valid_i = 1'b0;
    wait (pending_rows.size() == 0);
    send_item(65536, 0, 0, 0, 0, 0, 0, 65536, 0);
  endtask

  // mostly well-formed random cameras with some degenerate ones
  task automatic test_random(input int count);
    logic signed [31:0] e[3], t[3], u[3];
    int sel;
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[j] = rand_q(); t[j] = rand_q(); u[j] = rand_q();
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        t = e;
      end else if (sel == 1) begin
        u = '{0, 0, 0};
      end else if (sel == 2) begin
        // up along the direction, scaled
        for (int j = 0; j < 3; j++) begin
          e[j] = $signed($urandom) >>> 12;
          t[j] = e[j] + ($signed($urandom) >>> 20);
          u[j] = (e[j] - t[j]) * (($urandom_range(0, 1) == 0) ? 3 : -2);
        end
      end
      send_item(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    valid_i = 1'b0;
    ready_i = 1'b0;
    {eye_x_i, eye_y_i, eye_z_i} = '0;
    {target_x_i, target_y_i, target_z_i} = '0;
    {upward_x_i, upward_y_i, upward_z_i} = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_drain_pause();
    test_random(200);
    // last stretch without idling on either side
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random(50);
    @(negedge clk_i);
    valid_i = 1'b0;

    wait (pending_rows.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
